FILE: hw/rtl/voxel_label_to_hex_mesh_assert.svh
// Assertion macros for the voxel mesher.
`ifndef VOXEL_LABEL_TO_HEX_MESH_ASSERT_SVH
`define VOXEL_LABEL_TO_HEX_MESH_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define VLHM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VLHM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/vlhm_pkg.sv
// Package: constants and sizes shared by the voxel mesher files.
`default_nettype none
package vlhm_pkg;
  localparam int MAX_NX   = 512;
  localparam int MAX_NY   = 512;
  localparam int MAX_NZ   = 1024;
  localparam int ID_WIDTH = 32;

  localparam int PX_W     = $clog2(MAX_NX + 1);
  localparam int PY_W     = $clog2(MAX_NY + 1);
  localparam int PZ_W     = $clog2(MAX_NZ + 1);
  localparam int DIM_W    = 18;
  localparam int ROW_PITCH = MAX_NX + 1;
  localparam int DEPTH    = (MAX_NX + 1) * (MAX_NY + 1);
  localparam int ADDR_W   = $clog2(DEPTH);

  localparam int STAMP_W  = 16;
  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
  localparam int NID_W    = ID_WIDTH - 1;
  localparam int IDS_W    = ID_WIDTH + 1;
  localparam logic [IDS_W-1:0] ID_LIMIT = {2'b00, {(ID_WIDTH-1){1'b1}}};
  localparam int MEM_W    = STAMP_W + NID_W;

  // corner offsets, bit v is corner v
  localparam logic [7:0] CORNER_DX = 8'b0110_0110;
  localparam logic [7:0] CORNER_DY = 8'b1100_1100;
  localparam logic [7:0] CORNER_DZ = 8'b1111_0000;

  localparam logic [1:0] CFG_LABEL  = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic KIND_NODE = 1'b0;
  localparam logic KIND_ELEM = 1'b1;
endpackage
`default_nettype wire

FILE: hw/rtl/vlhm_ram.sv
// Generic simple dual-port RAM, one write port, registered read.
`default_nettype none
module vlhm_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/voxel_label_to_hex_mesh.sv
// Top level: voxel stream to hexahedron mesh with node deduplication.
//
// Input channel in_*: one label byte per transaction, raster order (x, then y,
// then z). Output channel out_*: node and element-corner records, one per
// transaction, held in an output register that is reloaded as it drains.
// Configuration (cfg_*) is a plain write port: label, width, height.
// A voxel that does not match the label only advances the position. A matching
// voxel goes through the accept step, node-store reads (four corner pairs
// through the two layer RAMs), a check step, one node record per new node
// (n = new nodes, 0..8), a hand-off step and eight element records.
// Each result passes through the output register.
// Node stores keep a slice stamp per entry. After reset a clearing pass runs
// before the first voxel is taken; the same pass, one entry a cycle, also runs
// when the stamp counter saturates (about every 65530 slices). During the pass
// in_stall is high.
// When out_stall is high the current record holds and the block waits to load the next one.
// After an id overflow record no further records appear until reset.
`default_nettype none
module voxel_label_to_hex_mesh
  import vlhm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_voxel_label,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [2:0]       out_corner,
  output logic [30:0]      out_node_id,
  output logic [9:0]       out_coord_x,
  output logic [9:0]       out_coord_y,
  output logic [10:0]      out_coord_z,
  output logic             out_last,
  output logic             out_overflow,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_wdata
);
  typedef enum logic [2:0] {S_SWEEP, S_IDLE, S_READ, S_CHECK, S_NODE, S_ELEM} state_t;

  state_t              state_r;
  logic [7:0]          label_r;
  logic [9:0]          width_r, height_r;
  logic [PX_W-1:0]     pos_x_r;
  logic [PY_W-1:0]     pos_y_r;
  logic [PZ_W-1:0]     pos_z_r;
  logic [ID_WIDTH-1:0] next_id_r;
  logic                ovf_r;
  logic                layer_sel_r;
  logic [STAMP_W-1:0]  epoch_r;
  logic [2:0]          rd_cnt_r;
  logic [7:0]          have_r, miss_r;
  logic [2:0]          cv_r;
  logic [NID_W-1:0]    id_r [8];
  logic [ADDR_W-1:0]   sw_rd_r, sw_wa_r;
  logic                sw_go_r, sw_wv_r, sw_keep_r;
  logic [STAMP_W-1:0]  sw_kstamp_r;

  logic                out_valid_r, out_kind_r, out_last_r, out_ovf_r;
  logic [2:0]          out_corner_r;
  logic [30:0]         out_id_r;
  logic [9:0]          out_cx_r, out_cy_r;
  logic [10:0]         out_cz_r;

  // ---------------- combinational ----------------
  logic              free, in_acc, match, adv;
  logic [2:0]        pick, csel;
  logic [DIM_W-1:0]  ax, ay, az;
  logic [ADDR_W-1:0] laddr, raddr;
  logic [MEM_W-1:0]  rd [2];
  logic [MEM_W-1:0]  wd [2];
  logic              we [2];
  logic [MEM_W-1:0]  lo_rd, up_rd;
  logic [3:0]        miss_cnt;
  logic [IDS_W-1:0]  id_need;
  logic              id_bad;
  logic [DIM_W-1:0]  ew, eh;
  logic              row_end, slice_end, zwrap, renorm;
  logic [STAMP_W:0]  ep_new;
  logic              node_go, pick_up;

  assign free   = !out_valid_r || !out_stall;
  assign in_acc = in_valid && !in_stall;
  assign match  = in_voxel_label == label_r;

  always_comb begin
    pick = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (miss_r[i]) pick = 3'(i);
    end
  end

  assign csel  = (state_r == S_NODE) ? pick : {1'b0, rd_cnt_r[1:0]};
  assign ax    = DIM_W'(pos_x_r) + DIM_W'(CORNER_DX[csel]);
  assign ay    = DIM_W'(pos_y_r) + DIM_W'(CORNER_DY[csel]);
  assign az    = DIM_W'(pos_z_r) + DIM_W'(CORNER_DZ[csel]);
  assign laddr = ADDR_W'(ay) * ADDR_W'(ROW_PITCH) + ADDR_W'(ax);
  assign raddr = (state_r == S_SWEEP) ? sw_rd_r : laddr;

  assign lo_rd = layer_sel_r ? rd[1] : rd[0];
  assign up_rd = layer_sel_r ? rd[0] : rd[1];

  assign miss_cnt = 4'($countones(~have_r));
  assign id_need  = {1'b0, next_id_r} + IDS_W'(miss_cnt) - IDS_W'(1);
  assign id_bad   = (miss_cnt != 4'd0) && (id_need > ID_LIMIT);

  assign node_go = (state_r == S_NODE) && (miss_r != 8'd0) && free;
  // physical store of the picked corner: upper layer when dz is set
  assign pick_up = CORNER_DZ[pick] ^ layer_sel_r;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      if (state_r == S_SWEEP) begin
        we[p] = sw_wv_r;
        if (sw_keep_r && (1'(p) == layer_sel_r)
            && (rd[p][MEM_W-1 -: STAMP_W] == sw_kstamp_r)) begin
          wd[p] = {STAMP_W'(1), rd[p][NID_W-1:0]};
        end else begin
          wd[p] = '0;
        end
      end else begin
        we[p] = node_go && (pick_up == 1'(p));
        wd[p] = {epoch_r + STAMP_W'(CORNER_DZ[pick]), next_id_r[NID_W-1:0]};
      end
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_layer
    vlhm_ram #(.W(MEM_W), .D(DEPTH)) u_ram (
      .clk   (clk),
      .we    (we[g]),
      .waddr ((state_r == S_SWEEP) ? sw_wa_r : laddr),
      .wdata (wd[g]),
      .raddr (raddr),
      .rdata (rd[g])
    );
  end

  // geometry with out-of-range sizes clamped
  always_comb begin
    if (width_r == 10'd0) ew = DIM_W'(1);
    else if (DIM_W'(width_r) > DIM_W'(MAX_NX)) ew = DIM_W'(MAX_NX);
    else ew = DIM_W'(width_r);
    if (height_r == 10'd0) eh = DIM_W'(1);
    else if (DIM_W'(height_r) > DIM_W'(MAX_NY)) eh = DIM_W'(MAX_NY);
    else eh = DIM_W'(height_r);
  end

  assign row_end   = DIM_W'(pos_x_r) + DIM_W'(1) >= ew;
  assign slice_end = row_end && (DIM_W'(pos_y_r) + DIM_W'(1) >= eh);
  assign zwrap     = DIM_W'(pos_z_r) + DIM_W'(1) >= DIM_W'(MAX_NZ);
  assign ep_new    = {1'b0, epoch_r} + (zwrap ? (STAMP_W+1)'(2) : (STAMP_W+1)'(1));
  assign renorm    = ep_new >= {1'b0, STAMP_MAX};

  assign adv = (state_r == S_IDLE && in_acc && !ovf_r && !match)
            || (state_r == S_ELEM && free && cv_r == 3'd7);

  assign in_stall = state_r != S_IDLE;

  // ---------------- sequential ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      label_r     <= 8'd1;
      width_r     <= 10'd512;
      height_r    <= 10'd512;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      pos_z_r     <= '0;
      next_id_r   <= '0;
      ovf_r       <= 1'b0;
      layer_sel_r <= 1'b0;
      epoch_r     <= STAMP_W'(1);
      rd_cnt_r    <= 3'd0;
      cv_r        <= 3'd0;
      sw_rd_r     <= '0;
      sw_go_r     <= 1'b1;
      sw_wv_r     <= 1'b0;
      sw_keep_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LABEL:  label_r  <= cfg_wdata[7:0];
          CFG_WIDTH:  width_r  <= cfg_wdata;
          CFG_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (!out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        S_SWEEP: begin
          if (sw_go_r) begin
            sw_rd_r <= sw_rd_r + ADDR_W'(1);
            if (sw_rd_r == ADDR_W'(DEPTH - 1)) sw_go_r <= 1'b0;
          end
          sw_wv_r <= sw_go_r;
          sw_wa_r <= sw_rd_r;
          if (sw_wv_r && sw_wa_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= S_IDLE;
            epoch_r <= STAMP_W'(1);
          end
        end
        S_IDLE: begin
          if (in_acc && !ovf_r && match) begin
            state_r  <= S_READ;
            rd_cnt_r <= 3'd0;
          end
        end
        S_READ: begin
          rd_cnt_r <= rd_cnt_r + 3'd1;
          if (rd_cnt_r != 3'd0) begin
            // data for corner pair (k, k+4) from the read issued last cycle
            have_r[rd_cnt_r - 3'd1] <= lo_rd[MEM_W-1 -: STAMP_W] == epoch_r;
            have_r[rd_cnt_r + 3'd3] <= up_rd[MEM_W-1 -: STAMP_W] == epoch_r + STAMP_W'(1);
            id_r[rd_cnt_r - 3'd1]   <= lo_rd[NID_W-1:0];
            id_r[rd_cnt_r + 3'd3]   <= up_rd[NID_W-1:0];
          end
          if (rd_cnt_r == 3'd4) state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (id_bad) begin
            if (free) begin
              out_valid_r  <= 1'b1;
              out_kind_r   <= KIND_NODE;
              out_corner_r <= 3'd0;
              out_id_r     <= '0;
              out_cx_r     <= '0;
              out_cy_r     <= '0;
              out_cz_r     <= '0;
              out_last_r   <= 1'b1;
              out_ovf_r    <= 1'b1;
              ovf_r        <= 1'b1;
              state_r      <= S_IDLE;
            end
          end else begin
            miss_r  <= ~have_r;
            state_r <= S_NODE;
          end
        end
        S_NODE: begin
          if (miss_r == 8'd0) begin
            state_r <= S_ELEM;
            cv_r    <= 3'd0;
          end else if (free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= KIND_NODE;
            out_corner_r <= pick;
            out_id_r     <= 31'(next_id_r);
            out_cx_r     <= ax[9:0];
            out_cy_r     <= ay[9:0];
            out_cz_r     <= az[10:0];
            out_last_r   <= 1'b0;
            out_ovf_r    <= 1'b0;
            id_r[pick]   <= next_id_r[NID_W-1:0];
            next_id_r    <= next_id_r + ID_WIDTH'(1);
            miss_r[pick] <= 1'b0;
          end
        end
        S_ELEM: begin
          if (free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= KIND_ELEM;
            out_corner_r <= cv_r;
            out_id_r     <= 31'(id_r[cv_r]);
            out_cx_r     <= '0;
            out_cy_r     <= '0;
            out_cz_r     <= '0;
            out_last_r   <= cv_r == 3'd7;
            out_ovf_r    <= 1'b0;
            cv_r         <= cv_r + 3'd1;
            if (cv_r == 3'd7) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (adv) begin
        if (!row_end) begin
          pos_x_r <= pos_x_r + PX_W'(1);
        end else begin
          pos_x_r <= '0;
          if (!slice_end) begin
            pos_y_r <= pos_y_r + PY_W'(1);
          end else begin
            pos_y_r     <= '0;
            layer_sel_r <= ~layer_sel_r;
            pos_z_r     <= zwrap ? '0 : pos_z_r + PZ_W'(1);
            if (renorm) begin
              // restamp: keep the new lower layer unless depth wraps, drop everything else
              state_r     <= S_SWEEP;
              sw_rd_r     <= '0;
              sw_go_r     <= 1'b1;
              sw_wv_r     <= 1'b0;
              sw_keep_r   <= !zwrap;
              sw_kstamp_r <= ep_new[STAMP_W-1:0];
            end else begin
              epoch_r <= ep_new[STAMP_W-1:0];
            end
          end
        end
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_corner   = out_corner_r;
  assign out_node_id  = out_id_r;
  assign out_coord_x  = out_cx_r;
  assign out_coord_y  = out_cy_r;
  assign out_coord_z  = out_cz_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

`include "voxel_label_to_hex_mesh_assert.svh"

  `VLHM_ASSERT_NXT(a_ovf_stops, out_valid && !out_stall && out_overflow, !out_valid, "record after overflow")
  `VLHM_ASSERT_IMP(a_elem_all_nodes, state_r == S_ELEM, miss_r == 8'd0, "element before nodes done")
  `VLHM_ASSERT_IMP(a_epoch_room, state_r != S_SWEEP, epoch_r != STAMP_MAX, "stamp counter saturated")
  `VLHM_ASSERT_IMP(a_one_write, state_r != S_SWEEP, !(we[0] && we[1]), "two store writes at once")
endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Testbench for voxel_label_to_hex_mesh: queue-fed driver, checking monitor, mesh predictor.
module tb_top
  import vlhm_pkg::*;
();

  localparam logic [1:0] CFG_SPARE = 2'd3;  // unmapped index, writes are dropped

  typedef struct packed {
    logic        kind;
    logic [2:0]  corner;
    logic [30:0] node_id;
    logic [9:0]  cx;
    logic [9:0]  cy;
    logic [10:0] cz;
    logic        last;
    logic        ovf;
  } mesh_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_voxel_label = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [2:0]  out_corner;
  logic [30:0] out_node_id;
  logic [9:0]  out_coord_x;
  logic [9:0]  out_coord_y;
  logic [10:0] out_coord_z;
  logic        out_last;
  logic        out_overflow;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [9:0]  cfg_wdata = '0;

  voxel_label_to_hex_mesh dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [7:0]  voxel_q[$];
  mesh_rec_t   mesh_q[$];
  int          err_cnt = 0;
  bit          quiet = 1'b0;

  // predictor state
  logic [7:0]  m_label;
  logic [9:0]  m_width, m_height;
  int unsigned m_px, m_py, m_pz;
  longint unsigned m_next_id, m_serial;
  bit          m_ovf;
  int unsigned m_sel;
  int unsigned node_ids[2][int];
  longint unsigned node_stamp[2][int];

  function automatic void rec_put(mesh_rec_t r);
    mesh_q.insert(mesh_q.size(), r);
  endfunction

  function automatic void voxel_put(logic [7:0] v);
    voxel_q.insert(voxel_q.size(), v);
  endfunction

  function automatic int unsigned clamp_dim(logic [9:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void step_position();
    if (m_px + 1 < clamp_dim(m_width, MAX_NX)) begin
      m_px++;
      return;
    end
    m_px = 0;
    if (m_py + 1 < clamp_dim(m_height, MAX_NY)) begin
      m_py++;
      return;
    end
    m_py = 0;
    m_sel ^= 1;
    if (m_pz + 1 < MAX_NZ) begin
      m_pz++;
      m_serial += 1;
    end else begin
      // depth wrap: both layers go stale
      m_pz = 0;
      m_serial += 2;
    end
  endfunction

  function automatic void mesh_voxel(logic [7:0] lbl);
    int idx[8];
    int unsigned st[8];
    longint unsigned want[8];
    bit have[8];
    longint unsigned missing;
    mesh_rec_t r;
    if (m_ovf) return;
    if (lbl != m_label) begin
      step_position();
      return;
    end
    missing = 0;
    for (int v = 0; v < 8; v++) begin
      idx[v] = int'((m_py + CORNER_DY[v]) * ROW_PITCH + m_px + CORNER_DX[v]);
      st[v] = CORNER_DZ[v] ? (m_sel ^ 1) : m_sel;
      want[v] = m_serial + CORNER_DZ[v];
      have[v] = node_stamp[st[v]].exists(idx[v]) && node_stamp[st[v]][idx[v]] == want[v];
      if (!have[v]) missing++;
    end
    if (missing != 0 && m_next_id + missing - 1 > 64'h7FFF_FFFF) begin
      m_ovf = 1'b1;
      r = '0;
      r.last = 1'b1;
      r.ovf = 1'b1;
      rec_put(r);
      return;
    end
    for (int v = 0; v < 8; v++) begin
      if (!have[v]) begin
        node_ids[st[v]][idx[v]] = 32'(m_next_id);
        node_stamp[st[v]][idx[v]] = want[v];
        r = '0;
        r.kind = KIND_NODE;
        r.corner = 3'(v);
        r.node_id = 31'(m_next_id);
        r.cx = 10'(m_px + CORNER_DX[v]);
        r.cy = 10'(m_py + CORNER_DY[v]);
        r.cz = 11'(m_pz + CORNER_DZ[v]);
        rec_put(r);
        m_next_id++;
      end
    end
    for (int v = 0; v < 8; v++) begin
      r = '0;
      r.kind = KIND_ELEM;
      r.corner = 3'(v);
      r.node_id = 31'(node_ids[st[v]][idx[v]]);
      r.last = (v == 7);
      rec_put(r);
    end
    step_position();
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_v);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, exp_v);
    err_cnt++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) mesh_voxel(in_voxel_label);
      if (!in_valid || !in_stall) begin
        if (voxel_q.size() != 0 && (quiet || $urandom_range(99) >= 13)) begin
          in_valid <= 1'b1;
          in_voxel_label <= voxel_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    mesh_rec_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mesh_q.size() == 0) begin
          report_mismatch("unexpected transaction, node_id", out_node_id, 0);
        end else begin
          e = mesh_q.pop_front();
          if (out_kind !== e.kind) report_mismatch("kind", out_kind, e.kind);
          if (out_corner !== e.corner) report_mismatch("corner", out_corner, e.corner);
          if (out_node_id !== e.node_id) report_mismatch("node_id", out_node_id, e.node_id);
          if (out_coord_x !== e.cx) report_mismatch("coord_x", out_coord_x, e.cx);
          if (out_coord_y !== e.cy) report_mismatch("coord_y", out_coord_y, e.cy);
          if (out_coord_z !== e.cz) report_mismatch("coord_z", out_coord_z, e.cz);
          if (out_last !== e.last) report_mismatch("last", out_last, e.last);
          if (out_overflow !== e.ovf) report_mismatch("overflow", out_overflow, e.ovf);
        end
      end
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 13);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_LABEL:  m_label = val[7:0];
      CFG_WIDTH:  m_width = val;
      CFG_HEIGHT: m_height = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (voxel_q.size() != 0 || in_valid || mesh_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // labels hit the configured value with at least the given percentage
  task automatic queue_voxels(int n, int hit_pct);
    for (int i = 0; i < n; i++)
      voxel_put($urandom_range(99) < hit_pct ? m_label : 8'($urandom));
  endtask

  initial begin
    m_label = 8'd1;
    m_width = 10'd512;
    m_height = 10'd512;
    m_px = 0; m_py = 0; m_pz = 0;
    m_next_id = 0; m_serial = 1; m_sel = 0; m_ovf = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset geometry, label extremes, shared and fresh corners
    voxel_q = '{8'd1, 8'd1, 8'd0, 8'd255, 8'd1, 8'd128, 8'd1, 8'd1, 8'd127, 8'd1};
    drain();

    // zero width and height clamp to 1: every voxel is a slice
    write_reg(CFG_LABEL, 10'd0);
    write_reg(CFG_WIDTH, 10'd0);
    write_reg(CFG_HEIGHT, 10'd0);
    queue_voxels(60, 30);
    drain();

    write_reg(CFG_SPARE, 10'h3FF);
    write_reg(CFG_LABEL, 10'd255);
    write_reg(CFG_WIDTH, 10'd1023);
    write_reg(CFG_HEIGHT, 10'd5);
    queue_voxels(40, 70);
    drain();

    write_reg(CFG_LABEL, 10'($urandom_range(255)));
    write_reg(CFG_WIDTH, 10'd4);
    write_reg(CFG_HEIGHT, 10'd3);
    queue_voxels(120, 70);
    drain();

    write_reg(CFG_LABEL, 10'd7);
    write_reg(CFG_WIDTH, 10'd2);
    write_reg(CFG_HEIGHT, 10'd1023);
    quiet = 1'b1;
    queue_voxels(40, 75);
    while (voxel_q.size() != 0) @(posedge clk);
    quiet = 1'b0;
    queue_voxels(50, 75);
    drain();

    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
